[hdl/flmd_pkg.sv]
package flmd_pkg;

	localparam int MAX_FRAME_BYTES = 32;
	localparam int LEN_CAP = (MAX_FRAME_BYTES < 32) ? MAX_FRAME_BYTES : 32;
	localparam int CNT_W = $clog2(LEN_CAP + 1);
	localparam int POS_W = $clog2(LEN_CAP);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [5:0] RST_PACKET_LENGTH = 6'd32;
	localparam logic [4:0] RST_TAIL_OFFSET = 5'd30;
	localparam logic [15:0] RST_HEAD_MARKER = 16'h0210;
	localparam logic [15:0] RST_TAIL_MARKER = 16'hAE12;
	localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd100;

	localparam logic [CNT_W-1:0] MIN_LEN = CNT_W'(4);
	localparam logic [CNT_W-1:0] MIN_TAIL = CNT_W'(2);
	localparam logic [15:0] GAP_MAX = 16'hFFFF;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PACKET_LENGTH = 3'd0,
		REG_TAIL_OFFSET = 3'd1,
		REG_HEAD_MARKER = 3'd2,
		REG_TAIL_MARKER = 3'd3,
		REG_TIMEOUT_TICKS = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic op;
		logic [7:0] data_byte;
		logic chunk_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic [4:0] byte_index;
		logic last_of_packet;
	} out_item_t;

	typedef struct packed {
		logic [5:0] packet_length;
		logic [4:0] tail_offset;
		logic [15:0] head_marker;
		logic [15:0] tail_marker;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [LEN_CAP-1:0][7:0] bytes;
		logic [CNT_W-1:0] len;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

[hdl/flmd_front.sv]
module flmd_front (
	input logic clk,
	input logic arst_n,
	input flmd_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input flmd_pkg::in_item_t in_item,
	input flmd_pkg::queue_status_t q_status,
	output logic push,
	output flmd_pkg::frame_t push_frame
);
	import flmd_pkg::*;

	logic [LEN_CAP-1:0][7:0] win_q;
	logic [LEN_CAP-1:0][7:0] win_n;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0] gap_q;
	logic pending_q;

	logic is_byte;
	logic is_tick;
	logic clear;
	logic [CNT_W-1:0] n_len;
	logic [CNT_W-1:0] t_pos;
	logic [4:0] t_raw;
	logic [CNT_W-1:0] cnt0;
	logic [CNT_W-1:0] cnt1;
	logic [CNT_W-1:0] cnt2;
	logic [LEN_CAP-1:0] head_eq;
	logic [LEN_CAP-1:0] tail_eq;
	logic [POS_W-1:0] hpos;
	logic [POS_W-1:0] tpos;
	logic win_full;
	logic match;

	assign in_ready = !q_status.full;
	assign is_byte = in_valid && in_ready && (in_item.op == OP_BYTE);
	assign is_tick = in_valid && in_ready && (in_item.op == OP_TICK);

	// clamp frame length and tail offset
	always_comb begin
		if (cfg.packet_length < 6'd4) begin
			n_len = MIN_LEN;
		end else if (int'(cfg.packet_length) > LEN_CAP) begin
			n_len = CNT_W'(LEN_CAP);
		end else begin
			n_len = CNT_W'(cfg.packet_length);
		end
		t_raw = cfg.tail_offset;
		if (t_raw < 5'd2) begin
			t_pos = MIN_TAIL;
		end else if (int'(t_raw) > int'(n_len - MIN_TAIL)) begin
			t_pos = n_len - MIN_TAIL;
		end else begin
			t_pos = CNT_W'(t_raw);
		end
	end

	assign clear = pending_q && (gap_q > cfg.timeout_ticks);
	assign cnt0 = clear ? '0 : cnt_q;
	assign cnt1 = (cnt0 >= n_len) ? n_len - CNT_W'(1) : cnt0;
	assign cnt2 = cnt1 + CNT_W'(1);

	// newest byte at position 0
	always_comb begin
		win_n[0] = in_item.data_byte;
		for (int i = 1; i < LEN_CAP; i++) begin
			win_n[i] = win_q[i-1];
		end
	end

	// marker compare at every pair position
	always_comb begin
		head_eq = '0;
		tail_eq = '0;
		for (int i = 0; i < LEN_CAP - 1; i++) begin
			head_eq[i] = ({win_n[i+1], win_n[i]} == cfg.head_marker);
			tail_eq[i] = ({win_n[i+1], win_n[i]} == cfg.tail_marker);
		end
	end

	assign hpos = POS_W'(n_len - MIN_TAIL);
	assign tpos = POS_W'(n_len - MIN_TAIL - t_pos);
	assign win_full = (cnt2 == n_len);
	assign match = win_full && head_eq[hpos] && tail_eq[tpos];

	assign push = is_byte && match;
	assign push_frame.bytes = win_n;
	assign push_frame.len = n_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			gap_q <= '0;
			pending_q <= 1'b1;
		end else if (is_tick) begin
			if (gap_q != GAP_MAX) begin
				gap_q <= gap_q + 16'd1;
			end
		end else if (is_byte) begin
			if (pending_q) begin
				gap_q <= '0;
			end
			pending_q <= in_item.chunk_last;
			if (match) begin
				cnt_q <= '0;
			end else if (win_full) begin
				cnt_q <= n_len - CNT_W'(1);
			end else begin
				cnt_q <= cnt2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_byte) begin
			win_q <= win_n;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(LEN_CAP))
		else $error("window count beyond capacity");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("frame pushed into full queue");

endmodule

[hdl/flmd_queue.sv]
module flmd_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input flmd_pkg::frame_t push_frame,
	input logic pop,
	output flmd_pkg::frame_t head_frame,
	output flmd_pkg::queue_status_t status
);
	import flmd_pkg::*;

	frame_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		if (int'(p) == QUEUE_DEPTH - 1) begin
			return '0;
		end
		return p + QPTR_W'(1);
	endfunction

	assign status.full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_frame = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("pop from empty frame queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + QCNT_W'(1))
		else $error("frame queue count lost a push");

endmodule

[hdl/flmd_back.sv]
module flmd_back (
	input logic clk,
	input logic arst_n,
	input flmd_pkg::queue_status_t q_status,
	input flmd_pkg::frame_t head_frame,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output flmd_pkg::out_item_t out_item
);
	import flmd_pkg::*;

	logic [POS_W-1:0] k_q;
	logic out_valid_q;
	out_item_t out_item_q;
	logic load;
	logic last;
	logic [POS_W-1:0] rd_idx;

	assign load = !q_status.empty && (!out_valid_q || out_ready);
	assign last = (CNT_W'(k_q) == head_frame.len - CNT_W'(1));
	assign rd_idx = POS_W'(head_frame.len - CNT_W'(1) - CNT_W'(k_q));
	assign pop = load && last;

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				k_q <= last ? '0 : k_q + POS_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q.packet_byte <= head_frame.bytes[rd_idx];
			out_item_q.byte_index <= 5'(k_q);
			out_item_q.last_of_packet <= last;
		end
	end

	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(load && $past(pop)) |-> k_q == '0)
		else $error("frame drain did not restart at byte zero");

endmodule

[hdl/fixed_length_marker_deframer_unit.sv]
// channel | direction | handshake            | payload
// in      | in        | in_valid / in_ready  | in_item: op, data_byte, chunk_last
// out     | out       | out_valid / out_ready| out_item: packet_byte, byte_index, last
// cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one input transaction per cycle while the two-entry frame queue has room
// a matched frame of n bytes leaves as n output transactions, one per cycle while out_ready is high
// the frame queue between front and back sets how long output stalls can be absorbed
// ticks and bytes both stop when the queue is full; cfg is always ready
// reset empties the window and queue at once, no clearing pass
module fixed_length_marker_deframer_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input flmd_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output flmd_pkg::out_item_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [flmd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [flmd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import flmd_pkg::*;

	cfg_t cfg_q;
	logic push;
	logic pop;
	frame_t push_frame;
	frame_t head_frame;
	queue_status_t q_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.packet_length <= RST_PACKET_LENGTH;
			cfg_q.tail_offset <= RST_TAIL_OFFSET;
			cfg_q.head_marker <= RST_HEAD_MARKER;
			cfg_q.tail_marker <= RST_TAIL_MARKER;
			cfg_q.timeout_ticks <= RST_TIMEOUT_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_PACKET_LENGTH: cfg_q.packet_length <= cfg_data[5:0];
				REG_TAIL_OFFSET: cfg_q.tail_offset <= cfg_data[4:0];
				REG_HEAD_MARKER: cfg_q.head_marker <= cfg_data;
				REG_TAIL_MARKER: cfg_q.tail_marker <= cfg_data;
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	flmd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.q_status(q_status),
		.push(push),
		.push_frame(push_frame)
	);

	flmd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_frame(push_frame),
		.pop(pop),
		.head_frame(head_frame),
		.status(q_status)
	);

	flmd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_status(q_status),
		.head_frame(head_frame),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

endmodule

[test/deframer_checker.sv]
module deframer_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input flmd_pkg::in_item_t in_item,
	input logic out_valid,
	input logic out_ready,
	input flmd_pkg::out_item_t out_item,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [flmd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [flmd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int errors,
	output int pending
);
	import flmd_pkg::*;

	logic [7:0] window [MAX_FRAME_BYTES];
	int oldest;
	logic [CNT_W-1:0] held;
	logic [15:0] silence;
	logic chunk_opening;
	cfg_t regs;
	out_item_t frame_bytes_due[$];
	out_item_t want;

	function automatic int slot_of(input int off);
		return (oldest + off) % MAX_FRAME_BYTES;
	endfunction

	function automatic void drop_oldest_bytes(input int k);
		oldest = slot_of(k);
		held = held - CNT_W'(k);
	endfunction

	function automatic void absorb_item(input in_item_t it);
		int n, t, k;
		out_item_t due;
		if (it.op == OP_TICK) begin
			if (silence != GAP_MAX)
				silence++;
			return;
		end
		if (chunk_opening) begin
			if (silence > regs.timeout_ticks) begin
				held = '0;
				oldest = 0;
			end
			silence = '0;
		end
		chunk_opening = it.chunk_last;
		n = int'(regs.packet_length);
		if (n < 4)
			n = 4;
		if (n > LEN_CAP)
			n = LEN_CAP;
		t = int'(regs.tail_offset);
		if (t < 2)
			t = 2;
		if (t > n - 2)
			t = n - 2;
		if (held >= n)
			drop_oldest_bytes(held - (n - 1));
		window[slot_of(held)] = it.data_byte;
		held++;
		if (held < n)
			return;
		if ({window[slot_of(0)], window[slot_of(1)]} != regs.head_marker ||
				{window[slot_of(t)], window[slot_of(t + 1)]} != regs.tail_marker) begin
			drop_oldest_bytes(1);
			return;
		end
		for (k = 0; k < n; k++) begin
			due = '{packet_byte: window[slot_of(k)], byte_index: 5'(k),
				last_of_packet: k == n - 1};
			frame_bytes_due.insert(frame_bytes_due.size(), due);
		end
		held = '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{packet_length: RST_PACKET_LENGTH, tail_offset: RST_TAIL_OFFSET,
				head_marker: RST_HEAD_MARKER, tail_marker: RST_TAIL_MARKER,
				timeout_ticks: RST_TIMEOUT_TICKS};
			oldest = 0;
			held = '0;
			silence = '0;
			chunk_opening = 1'b1;
			frame_bytes_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PACKET_LENGTH: regs.packet_length = cfg_data[5:0];
					REG_TAIL_OFFSET: regs.tail_offset = cfg_data[4:0];
					REG_HEAD_MARKER: regs.head_marker = cfg_data;
					REG_TAIL_MARKER: regs.tail_marker = cfg_data;
					REG_TIMEOUT_TICKS: regs.timeout_ticks = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (frame_bytes_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected frame byte %h index %0d last %b", $time,
						out_item.packet_byte, out_item.byte_index, out_item.last_of_packet);
				end else begin
					want = frame_bytes_due.pop_front();
					if (out_item.packet_byte !== want.packet_byte ||
							out_item.byte_index !== want.byte_index ||
							out_item.last_of_packet !== want.last_of_packet) begin
						errors++;
						$display("%0t: frame byte mismatch, expected %h/%0d/%b, actual %h/%0d/%b",
							$time, want.packet_byte, want.byte_index, want.last_of_packet,
							out_item.packet_byte, out_item.byte_index, out_item.last_of_packet);
					end
				end
			end
			if (in_valid && in_ready)
				absorb_item(in_item);
			pending = frame_bytes_due.size();
		end
	end

endmodule

[test/tb.sv]
module tb;
	import flmd_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_ITEMS = 220;
	localparam int IDLE_PCT = 22;
	localparam int QUIET_TICKS = 12;
	localparam logic [CFG_INDEX_W-1:0] FIRST_SPARE_INDEX = REG_TIMEOUT_TICKS + 3'd1;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_item;
	logic out_valid;
	logic out_ready;
	out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int errors;
	int pending;

	bit steady = 1'b0;
	int hold_asked = 0;
	int hold_done = 0;
	int items_sent = 0;
	int quiet = 0;
	cfg_t live;

	fixed_length_marker_deframer_unit DUT (.*);

	deframer_checker watch (.*);

	always #2 clk = ~clk;

	// watchdog on all three channels
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else if (quiet == WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	initial begin : receiver
		int i;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_done < hold_asked) begin
				out_ready <= 1'b0;
				for (i = 0; i < HOLD_CYCLES; i++)
					@(negedge clk);
				hold_done++;
			end else
				out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	function automatic int frame_size(input logic [5:0] len);
		return len < 4 ? 4 : len > LEN_CAP ? LEN_CAP : int'(len);
	endfunction

	task automatic put_item(input logic kind, input logic [7:0] value, input logic ends_chunk);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{op: kind, data_byte: value, chunk_last: ends_chunk};
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic drain(input int cycles);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (cycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic configure(input cfg_t c);
		drain(SETTLE_CYCLES);
		live = c;
		write_reg(REG_PACKET_LENGTH, {10'($urandom), c.packet_length});
		write_reg(REG_TAIL_OFFSET, {11'($urandom), c.tail_offset});
		write_reg(REG_HEAD_MARKER, c.head_marker);
		write_reg(REG_TAIL_MARKER, c.tail_marker);
		write_reg(REG_TIMEOUT_TICKS, c.timeout_ticks);
		write_reg(FIRST_SPARE_INDEX + 3'($urandom_range(0, 2)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// markers at their clamped spots, one marker bit flipped when broken, random payload, random chunk breaks
	task automatic send_frame(input bit broken);
		logic [7:0] bytes [LEN_CAP];
		int n, t, k, hit;
		n = frame_size(live.packet_length);
		t = live.tail_offset < 2 ? 2 : live.tail_offset > n - 2 ? n - 2 : int'(live.tail_offset);
		for (k = 0; k < n; k++)
			bytes[k] = 8'($urandom);
		{bytes[0], bytes[1]} = live.head_marker;
		{bytes[t], bytes[t + 1]} = live.tail_marker;
		if (broken) begin
			case ($urandom_range(0, 3))
				0: hit = 0;
				1: hit = 1;
				2: hit = t;
				default: hit = t + 1;
			endcase
			bytes[hit] = bytes[hit] ^ 8'(1 << $urandom_range(0, 7));
		end
		for (k = 0; k < n; k++)
			put_item(OP_BYTE, bytes[k], k == n - 1 || $urandom_range(0, 7) == 0);
	endtask

	initial begin
		cfg_t c;
		int goal, phase_end, phase, r, n;
		bit squeeze;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		live = '{packet_length: RST_PACKET_LENGTH, tail_offset: RST_TAIL_OFFSET,
			head_marker: RST_HEAD_MARKER, tail_marker: RST_TAIL_MARKER,
			timeout_ticks: RST_TIMEOUT_TICKS};
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, window only partly filled
		put_item(OP_BYTE, 8'h00, 1'b0);
		put_item(OP_BYTE, 8'hFF, 1'b1);
		put_item(OP_TICK, 8'h5A, 1'b1);
		put_item(OP_BYTE, 8'h02, 1'b1);

		// shortest frame, zero timeout clears a chunk after silence
		configure('{packet_length: 6'd4, tail_offset: 5'd2, head_marker: 16'hFFFF,
			tail_marker: 16'h0000, timeout_ticks: 16'd0});
		put_item(OP_BYTE, 8'hFF, 1'b0);
		put_item(OP_BYTE, 8'hFF, 1'b0);
		put_item(OP_BYTE, 8'h00, 1'b0);
		put_item(OP_BYTE, 8'h00, 1'b1);
		put_item(OP_BYTE, 8'hFF, 1'b0);
		put_item(OP_BYTE, 8'hFF, 1'b1);
		put_item(OP_TICK, 8'hA5, 1'b0);
		put_item(OP_TICK, 8'h3C, 1'b1);
		put_item(OP_BYTE, 8'h00, 1'b0);
		put_item(OP_BYTE, 8'h00, 1'b1);

		// length and tail offset below and above their ranges, resync over stale bytes
		configure('{packet_length: 6'd0, tail_offset: 5'd31, head_marker: RST_HEAD_MARKER,
			tail_marker: RST_TAIL_MARKER, timeout_ticks: 16'hFFFF});
		put_item(OP_BYTE, 8'h02, 1'b0);
		put_item(OP_BYTE, 8'h10, 1'b0);
		put_item(OP_BYTE, 8'hAE, 1'b0);
		put_item(OP_BYTE, 8'h12, 1'b1);

		// fill a long window, then shrink the length under it
		configure('{packet_length: 6'd63, tail_offset: 5'd0, head_marker: RST_HEAD_MARKER,
			tail_marker: RST_TAIL_MARKER, timeout_ticks: 16'hFFFF});
		put_item(OP_BYTE, 8'h02, 1'b0);
		put_item(OP_BYTE, 8'h10, 1'b0);
		put_item(OP_BYTE, 8'hAE, 1'b0);
		put_item(OP_BYTE, 8'h12, 1'b0);
		put_item(OP_BYTE, 8'h55, 1'b0);
		put_item(OP_BYTE, 8'h66, 1'b0);
		configure('{packet_length: 6'd5, tail_offset: 5'd3, head_marker: RST_HEAD_MARKER,
			tail_marker: RST_TAIL_MARKER, timeout_ticks: 16'hFFFF});
		put_item(OP_BYTE, 8'h02, 1'b0);
		put_item(OP_BYTE, 8'h10, 1'b0);
		put_item(OP_BYTE, 8'h77, 1'b0);
		put_item(OP_BYTE, 8'hAE, 1'b0);
		put_item(OP_BYTE, 8'h12, 1'b1);

		// the largest timeout keeps a chunk across silence
		put_item(OP_BYTE, 8'h02, 1'b0);
		put_item(OP_BYTE, 8'h10, 1'b1);
		steady = 1'b1;
		repeat (QUIET_TICKS) put_item(OP_TICK, 8'($urandom), 1'($urandom));
		steady = 1'b0;
		put_item(OP_BYTE, 8'h00, 1'b0);
		put_item(OP_BYTE, 8'hAE, 1'b0);
		put_item(OP_BYTE, 8'h12, 1'b1);

		phase = 0;
		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			squeeze = phase == 2;
			r = $urandom_range(0, 9);
			c.packet_length = squeeze ? 6'($urandom_range(4, 8)) :
				r < 6 ? 6'($urandom_range(4, 10)) : r == 6 ? 6'd4 : r == 7 ? 6'd32 :
				r == 8 ? 6'($urandom_range(33, 63)) : 6'($urandom_range(0, 3));
			n = frame_size(c.packet_length);
			r = $urandom_range(0, 9);
			c.tail_offset = r < 7 ? 5'($urandom_range(2, n - 2)) :
				r == 7 ? 5'($urandom_range(0, 1)) : r == 8 ? 5'(n - 2) :
				5'($urandom_range(n - 1, 31));
			r = $urandom_range(0, 7);
			c.head_marker = r == 0 ? 16'h0000 : r == 1 ? 16'hFFFF : 16'($urandom);
			r = $urandom_range(0, 7);
			c.tail_marker = r == 0 ? 16'h0000 : r == 1 ? 16'hFFFF : 16'($urandom);
			r = $urandom_range(0, 9);
			c.timeout_ticks = squeeze ? 16'hFFFF : r < 6 ? 16'($urandom_range(0, 8)) :
				r == 6 ? 16'd0 : r == 7 ? 16'hFFFF : 16'($urandom);
			configure(c);
			steady = phase == 1 || squeeze;
			if (squeeze) begin
				// receiver stalls while frames keep coming
				hold_asked++;
				repeat (8) send_frame(1'b0);
			end else begin
				phase_end = items_sent + $urandom_range(20, 40);
				while (items_sent < phase_end) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: send_frame(1'b0);
						6: send_frame(1'b1);
						7: repeat ($urandom_range(1, 6))
							put_item(OP_BYTE, 8'($urandom), 1'($urandom));
						default: repeat ($urandom_range(1, 10))
							put_item(OP_TICK, 8'($urandom), 1'($urandom));
					endcase
				end
			end
			steady = 1'b0;
			phase++;
		end

		drain(TAIL_CYCLES);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
